// ===== sv/quadratic_least_squares_fit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic fit block
// Shared property forms, clocked on clk and masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_LEAST_SQUARES_FIT_ASSERT_SVH
`define QUADRATIC_LEAST_SQUARES_FIT_ASSERT_SVH

// same-cycle implication
`define QLSF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qlsf check failed");

// next-cycle implication
`define QLSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qlsf check failed");

`endif

// ===== sv/qlsf_pkg.sv =====
// ----------------------------------------------------------------------------
// qlsf_pkg
// Widths, operand codes and the solve microprogram of the quadratic fit.
// ----------------------------------------------------------------------------
package qlsf_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int X_W            = 10;
    localparam int Y_W            = 9;
    localparam int COEF_W         = 48;
    localparam int USED_W         = 11;
    localparam int WIDE_W         = 192;
    localparam int FRAC_CONST     = 16;
    localparam int FRAC_LINEAR    = 32;
    localparam int FRAC_SQUARE    = 40;

    // multiplicand selectors
    localparam logic [3:0] A_P0  = 4'd0;
    localparam logic [3:0] A_P1  = 4'd1;
    localparam logic [3:0] A_P2  = 4'd2;
    localparam logic [3:0] A_P3  = 4'd3;
    localparam logic [3:0] A_P4  = 4'd4;
    localparam logic [3:0] A_C00 = 4'd5;
    localparam logic [3:0] A_C01 = 4'd6;
    localparam logic [3:0] A_C02 = 4'd7;
    localparam logic [3:0] A_C11 = 4'd8;
    localparam logic [3:0] A_C12 = 4'd9;
    localparam logic [3:0] A_C22 = 4'd10;

    // multiplier selectors
    localparam logic [2:0] B_P0 = 3'd0;
    localparam logic [2:0] B_P1 = 3'd1;
    localparam logic [2:0] B_P2 = 3'd2;
    localparam logic [2:0] B_P3 = 3'd3;
    localparam logic [2:0] B_P4 = 3'd4;
    localparam logic [2:0] B_R0 = 3'd5;
    localparam logic [2:0] B_R1 = 3'd6;
    localparam logic [2:0] B_R2 = 3'd7;

    // result file slots, cofactors first in multiplicand order
    localparam int         FILE_DEPTH = 10;
    localparam logic [3:0] F_C00 = 4'd0;
    localparam logic [3:0] F_C01 = 4'd1;
    localparam logic [3:0] F_C02 = 4'd2;
    localparam logic [3:0] F_C11 = 4'd3;
    localparam logic [3:0] F_C12 = 4'd4;
    localparam logic [3:0] F_C22 = 4'd5;
    localparam logic [3:0] F_DET = 4'd6;
    localparam logic [3:0] F_N0  = 4'd7;
    localparam logic [3:0] F_N1  = 4'd8;
    localparam logic [3:0] F_N2  = 4'd9;

    localparam int         UOP_W    = 5;
    localparam logic [4:0] UOP_LAST = 5'd23;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dst;
    } uop_t;

    function automatic uop_t mk_uop(input logic [3:0] a, input logic [2:0] b,
                                    input logic n, input logic f, input logic l,
                                    input logic [3:0] d);
        uop_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.neg   = n;
        u.first = f;
        u.last  = l;
        u.dst   = d;
        return u;
    endfunction

    // acc = sum of +/- a*b terms, written to dst on the last term
    function automatic uop_t uop_at(input logic [UOP_W-1:0] idx);
        uop_t u;
        case (idx)
            5'd0:    u = mk_uop(A_P2,  B_P4, 1'b0, 1'b1, 1'b0, F_C00);
            5'd1:    u = mk_uop(A_P3,  B_P3, 1'b1, 1'b0, 1'b1, F_C00);
            5'd2:    u = mk_uop(A_P1,  B_P4, 1'b0, 1'b1, 1'b0, F_C01);
            5'd3:    u = mk_uop(A_P2,  B_P3, 1'b1, 1'b0, 1'b1, F_C01);
            5'd4:    u = mk_uop(A_P1,  B_P3, 1'b0, 1'b1, 1'b0, F_C02);
            5'd5:    u = mk_uop(A_P2,  B_P2, 1'b1, 1'b0, 1'b1, F_C02);
            5'd6:    u = mk_uop(A_P0,  B_P4, 1'b0, 1'b1, 1'b0, F_C11);
            5'd7:    u = mk_uop(A_P2,  B_P2, 1'b1, 1'b0, 1'b1, F_C11);
            5'd8:    u = mk_uop(A_P0,  B_P3, 1'b0, 1'b1, 1'b0, F_C12);
            5'd9:    u = mk_uop(A_P1,  B_P2, 1'b1, 1'b0, 1'b1, F_C12);
            5'd10:   u = mk_uop(A_P0,  B_P2, 1'b0, 1'b1, 1'b0, F_C22);
            5'd11:   u = mk_uop(A_P1,  B_P1, 1'b1, 1'b0, 1'b1, F_C22);
            5'd12:   u = mk_uop(A_C00, B_P0, 1'b0, 1'b1, 1'b0, F_DET);
            5'd13:   u = mk_uop(A_C01, B_P1, 1'b1, 1'b0, 1'b0, F_DET);
            5'd14:   u = mk_uop(A_C02, B_P2, 1'b0, 1'b0, 1'b1, F_DET);
            5'd15:   u = mk_uop(A_C00, B_R0, 1'b0, 1'b1, 1'b0, F_N0);
            5'd16:   u = mk_uop(A_C01, B_R1, 1'b1, 1'b0, 1'b0, F_N0);
            5'd17:   u = mk_uop(A_C02, B_R2, 1'b0, 1'b0, 1'b1, F_N0);
            5'd18:   u = mk_uop(A_C01, B_R0, 1'b1, 1'b1, 1'b0, F_N1);
            5'd19:   u = mk_uop(A_C11, B_R1, 1'b0, 1'b0, 1'b0, F_N1);
            5'd20:   u = mk_uop(A_C12, B_R2, 1'b1, 1'b0, 1'b1, F_N1);
            5'd21:   u = mk_uop(A_C02, B_R0, 1'b0, 1'b1, 1'b0, F_N2);
            5'd22:   u = mk_uop(A_C12, B_R1, 1'b1, 1'b0, 1'b0, F_N2);
            5'd23:   u = mk_uop(A_C22, B_R2, 1'b0, 1'b0, 1'b1, F_N2);
            default: u = mk_uop(A_P0,  B_P0, 1'b0, 1'b0, 1'b0, F_C00);
        endcase
        return u;
    endfunction

endpackage

// ===== sv/qlsf_if.sv =====
// ----------------------------------------------------------------------------
// qlsf interfaces
// Valid/ready channels for incoming points and outgoing fit results.
// ----------------------------------------------------------------------------
interface qlsf_point_if;
    logic                        valid;
    logic                        ready;
    logic [qlsf_pkg::X_W-1:0]    point_x;
    logic [qlsf_pkg::Y_W-1:0]    point_y;
    logic                        last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface qlsf_fit_if;
    logic                          valid;
    logic                          ready;
    logic [qlsf_pkg::COEF_W-1:0]   coef_const;
    logic [qlsf_pkg::COEF_W-1:0]   coef_linear;
    logic [qlsf_pkg::COEF_W-1:0]   coef_square;
    logic                          singular;
    logic                          points_dropped;
    logic [qlsf_pkg::USED_W-1:0]   points_used;

    modport source (output valid, output coef_const, output coef_linear,
                    output coef_square, output singular, output points_dropped,
                    output points_used, input ready);
    modport sink   (input valid, input coef_const, input coef_linear,
                    input coef_square, input singular, input points_dropped,
                    input points_used, output ready);
endinterface

// ===== sv/quadratic_least_squares_fit.sv =====
// Point intake: each accepted point runs 6 multiply steps on one 30x10 multiplier;
// a point dropped at capacity skips them. Ready is low while a point is in work.
// Solve after the last point: 24 shift-add terms on one 192-bit adder, then three
// divisions unless the determinant is zero; the next set may be taken meanwhile.
// Reset (rst_n low, asynchronous) clears all sums, the count and both sequencers.
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Quadratic least-squares fit of pixel points, y = a0 + a1*x + a2*x^2.
// ----------------------------------------------------------------------------
module quadratic_least_squares_fit #(
    parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qlsf_point_if.sink  points,
    qlsf_fit_if.source  coefs
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic               start;
    logic               solve_busy;
    logic               overflow;
    logic [CNT_W-1:0]   p0;
    logic [CNT_W+9:0]   p1;
    logic [CNT_W+19:0]  p2;
    logic [CNT_W+29:0]  p3;
    logic [CNT_W+39:0]  p4;
    logic [CNT_W+8:0]   r0;
    logic [CNT_W+18:0]  r1;
    logic [CNT_W+28:0]  r2;

    qlsf_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (points.valid),
        .in_ready   (points.ready),
        .point_x    (points.point_x),
        .point_y    (points.point_y),
        .last_point (points.last_point),
        .solve_busy (solve_busy),
        .start      (start),
        .p0         (p0),
        .p1         (p1),
        .p2         (p2),
        .p3         (p3),
        .p4         (p4),
        .r0         (r0),
        .r1         (r1),
        .r2         (r2),
        .overflow   (overflow)
    );

    qlsf_solve #(.MAX_POINTS(MAX_POINTS)) u_solve (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (solve_busy),
        .p0             (p0),
        .p1             (p1),
        .p2             (p2),
        .p3             (p3),
        .p4             (p4),
        .r0             (r0),
        .r1             (r1),
        .r2             (r2),
        .overflow       (overflow),
        .out_valid      (coefs.valid),
        .out_ready      (coefs.ready),
        .coef_const     (coefs.coef_const),
        .coef_linear    (coefs.coef_linear),
        .coef_square    (coefs.coef_square),
        .singular       (coefs.singular),
        .points_dropped (coefs.points_dropped),
        .points_used    (coefs.points_used)
    );

endmodule

// ===== sv/qlsf_accum.sv =====
// ----------------------------------------------------------------------------
// qlsf_accum
// Power sums of the point set, formed with one shared 30x10 multiplier.
// ----------------------------------------------------------------------------
module qlsf_accum #(
    parameter  int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
    localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [qlsf_pkg::X_W-1:0]     point_x,
    input  logic [qlsf_pkg::Y_W-1:0]     point_y,
    input  logic                         last_point,
    input  logic                         solve_busy,
    output logic                         start,
    output logic [CNT_W-1:0]             p0,
    output logic [CNT_W+9:0]             p1,
    output logic [CNT_W+19:0]            p2,
    output logic [CNT_W+29:0]            p3,
    output logic [CNT_W+39:0]            p4,
    output logic [CNT_W+8:0]             r0,
    output logic [CNT_W+18:0]            r1,
    output logic [CNT_W+28:0]            r2,
    output logic                         overflow
);

    localparam int S1_W = CNT_W + 10;
    localparam int S2_W = CNT_W + 20;
    localparam int S3_W = CNT_W + 30;
    localparam int S4_W = CNT_W + 40;
    localparam int R0_W = CNT_W + 9;
    localparam int R1_W = CNT_W + 19;
    localparam int R2_W = CNT_W + 29;

    localparam logic [1:0] AS_IDLE = 2'd0;
    localparam logic [1:0] AS_MUL  = 2'd1;
    localparam logic [1:0] AS_FIN  = 2'd2;

    logic [1:0]                  state_reg;
    logic [2:0]                  step_reg;
    logic [qlsf_pkg::X_W-1:0]    x_reg;
    logic [qlsf_pkg::Y_W-1:0]    y_reg;
    logic                        last_reg;
    logic [19:0]                 x2_reg;
    logic [39:0]                 prod_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [S1_W-1:0]             s1_reg;
    logic [S2_W-1:0]             s2_reg;
    logic [S3_W-1:0]             s3_reg;
    logic [S4_W-1:0]             s4_reg;
    logic [R0_W-1:0]             t0_reg;
    logic [R1_W-1:0]             t1_reg;
    logic [R2_W-1:0]             t2_reg;
    logic                        ovf_reg;
    logic [29:0]                 mul_a;
    logic [9:0]                  mul_b;
    logic [39:0]                 mul_res;
    logic                        accept;

    assign in_ready = (state_reg == AS_IDLE);
    assign accept   = in_valid && in_ready;
    assign start    = (state_reg == AS_FIN) && last_reg && !solve_busy;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = 30'(x_reg);
                mul_b = x_reg;
            end
            3'd1, 3'd2:
            begin
                mul_a = prod_reg[29:0];
                mul_b = x_reg;
            end
            3'd3:
            begin
                mul_a = 30'(x2_reg);
                mul_b = 10'(y_reg);
            end
            3'd4:
            begin
                mul_a = 30'(x_reg);
                mul_b = 10'(y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = 40'(mul_a) * 40'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
            s3_reg    <= '0;
            s4_reg    <= '0;
            t0_reg    <= '0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            ovf_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                AS_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg    <= point_x;
                        y_reg    <= point_y;
                        last_reg <= last_point;
                        step_reg <= '0;
                        if (cnt_reg < CNT_W'(MAX_POINTS))
                        begin
                            state_reg <= AS_MUL;
                        end
                        else
                        begin
                            // capacity full: drop the point, keep the flag
                            ovf_reg   <= 1'b1;
                            state_reg <= AS_FIN;
                        end
                    end
                end
                AS_MUL:
                begin
                    prod_reg <= mul_res;
                    step_reg <= step_reg + 3'd1;
                    case (step_reg)
                        3'd0:
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                            s1_reg  <= s1_reg + S1_W'(x_reg);
                            t0_reg  <= t0_reg + R0_W'(y_reg);
                        end
                        3'd1:
                        begin
                            x2_reg <= prod_reg[19:0];
                            s2_reg <= s2_reg + S2_W'(prod_reg[19:0]);
                        end
                        3'd2:    s3_reg <= s3_reg + S3_W'(prod_reg[29:0]);
                        3'd3:    s4_reg <= s4_reg + S4_W'(prod_reg);
                        3'd4:    t2_reg <= t2_reg + R2_W'(prod_reg[28:0]);
                        3'd5:
                        begin
                            t1_reg    <= t1_reg + R1_W'(prod_reg[18:0]);
                            state_reg <= AS_FIN;
                        end
                        default: state_reg <= AS_FIN;
                    endcase
                end
                AS_FIN:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= AS_IDLE;
                    end
                    else if (!solve_busy)
                    begin
                        // solver takes the sums on this edge; start a fresh set
                        cnt_reg   <= '0;
                        s1_reg    <= '0;
                        s2_reg    <= '0;
                        s3_reg    <= '0;
                        s4_reg    <= '0;
                        t0_reg    <= '0;
                        t1_reg    <= '0;
                        t2_reg    <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= AS_IDLE;
                    end
                end
                default: state_reg <= AS_IDLE;
            endcase
        end
    end

    assign p0       = cnt_reg;
    assign p1       = s1_reg;
    assign p2       = s2_reg;
    assign p3       = s3_reg;
    assign p4       = s4_reg;
    assign r0       = t0_reg;
    assign r1       = t1_reg;
    assign r2       = t2_reg;
    assign overflow = ovf_reg;

endmodule

// ===== sv/qlsf_solve.sv =====
// ----------------------------------------------------------------------------
// qlsf_solve
// Cramer solve of the 3x3 normal equations on one shared wide adder:
// shift-add products under a microprogram, then restoring division.
// ----------------------------------------------------------------------------
module qlsf_solve #(
    parameter  int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
    localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [CNT_W-1:0]                  p0,
    input  logic [CNT_W+9:0]                  p1,
    input  logic [CNT_W+19:0]                 p2,
    input  logic [CNT_W+29:0]                 p3,
    input  logic [CNT_W+39:0]                 p4,
    input  logic [CNT_W+8:0]                  r0,
    input  logic [CNT_W+18:0]                 r1,
    input  logic [CNT_W+28:0]                 r2,
    input  logic                              overflow,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [qlsf_pkg::COEF_W-1:0]       coef_const,
    output logic [qlsf_pkg::COEF_W-1:0]       coef_linear,
    output logic [qlsf_pkg::COEF_W-1:0]       coef_square,
    output logic                              singular,
    output logic                              points_dropped,
    output logic [qlsf_pkg::USED_W-1:0]       points_used
);

    localparam int W     = qlsf_pkg::WIDE_W;
    localparam int CW    = qlsf_pkg::COEF_W;
    localparam int SB    = CNT_W + 40;
    localparam int BIT_W = $clog2(W);

    localparam logic [2:0] SS_IDLE  = 3'd0;
    localparam logic [2:0] SS_LOAD  = 3'd1;
    localparam logic [2:0] SS_MAC   = 3'd2;
    localparam logic [2:0] SS_DLOAD = 3'd3;
    localparam logic [2:0] SS_DADD  = 3'd4;
    localparam logic [2:0] SS_DIV   = 3'd5;
    localparam logic [2:0] SS_DFIN  = 3'd6;
    localparam logic [2:0] SS_DONE  = 3'd7;

    localparam logic [1:0] K_CONST  = 2'd0;
    localparam logic [1:0] K_LINEAR = 2'd1;
    localparam logic [1:0] K_SQUARE = 2'd2;

    localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

    logic [2:0]                        state_reg;
    logic                              valid_reg;
    logic [CNT_W-1:0]                  p0_reg;
    logic [CNT_W+9:0]                  p1_reg;
    logic [CNT_W+19:0]                 p2_reg;
    logic [CNT_W+29:0]                 p3_reg;
    logic [CNT_W+39:0]                 p4_reg;
    logic [CNT_W+8:0]                  r0_reg;
    logic [CNT_W+18:0]                 r1_reg;
    logic [CNT_W+28:0]                 r2_reg;
    logic [W-1:0]                      file_reg [qlsf_pkg::FILE_DEPTH];
    logic [W-1:0]                      acc_reg;
    logic [W-1:0]                      mcand_reg;
    logic [SB-1:0]                     mplier_reg;
    logic [qlsf_pkg::UOP_W-1:0]        uop_idx_reg;
    logic [1:0]                        k_reg;
    logic [W-1:0]                      ad_reg;
    logic [W-1:0]                      rem_reg;
    logic [W-1:0]                      dq_reg;
    logic [BIT_W-1:0]                  bit_reg;
    logic                              neg_reg;
    logic [CW-1:0]                     c0_reg;
    logic [CW-1:0]                     c1_reg;
    logic [CW-1:0]                     c2_reg;
    logic                              sing_reg;
    logic                              drop_reg;
    logic [qlsf_pkg::USED_W-1:0]       used_reg;

    qlsf_pkg::uop_t                    uop;
    logic [3:0]                        rd_idx;
    logic [W-1:0]                      rd_data;
    logic [W-1:0]                      det;
    logic [W-1:0]                      mag_n;
    logic [W-1:0]                      mag_d;
    logic [W-1:0]                      num_sh;
    logic [W-1:0]                      a_val;
    logic [SB-1:0]                     b_val;
    logic [W-1:0]                      add_a;
    logic [W-1:0]                      add_b;
    logic                              add_sub;
    logic [W:0]                        add_res;
    logic [W-1:0]                      rem_sh;
    logic                              q_fit;
    logic [CW-1:0]                     lim;
    logic [CW-1:0]                     mag_q;
    logic [CW-1:0]                     coef_val;

    assign uop     = qlsf_pkg::uop_at(uop_idx_reg);
    assign rd_idx  = (state_reg == SS_DLOAD) ? (qlsf_pkg::F_N0 + {2'b00, k_reg})
                                             : (uop.a_sel - qlsf_pkg::A_C00);
    assign rd_data = file_reg[rd_idx];
    assign det     = file_reg[qlsf_pkg::F_DET];
    assign mag_n   = rd_data[W-1] ? (~rd_data + W'(1)) : rd_data;
    assign mag_d   = det[W-1] ? (~det + W'(1)) : det;

    always_comb
    begin
        case (k_reg)
            K_CONST:  num_sh = mag_n << (qlsf_pkg::FRAC_CONST + 1);
            K_LINEAR: num_sh = mag_n << (qlsf_pkg::FRAC_LINEAR + 1);
            default:  num_sh = mag_n << (qlsf_pkg::FRAC_SQUARE + 1);
        endcase
    end

    always_comb
    begin
        case (uop.a_sel)
            qlsf_pkg::A_P0: a_val = W'(p0_reg);
            qlsf_pkg::A_P1: a_val = W'(p1_reg);
            qlsf_pkg::A_P2: a_val = W'(p2_reg);
            qlsf_pkg::A_P3: a_val = W'(p3_reg);
            qlsf_pkg::A_P4: a_val = W'(p4_reg);
            default:        a_val = rd_data;
        endcase
    end

    always_comb
    begin
        case (uop.b_sel)
            qlsf_pkg::B_P0: b_val = SB'(p0_reg);
            qlsf_pkg::B_P1: b_val = SB'(p1_reg);
            qlsf_pkg::B_P2: b_val = SB'(p2_reg);
            qlsf_pkg::B_P3: b_val = SB'(p3_reg);
            qlsf_pkg::B_P4: b_val = p4_reg;
            qlsf_pkg::B_R0: b_val = SB'(r0_reg);
            qlsf_pkg::B_R1: b_val = SB'(r1_reg);
            default:        b_val = SB'(r2_reg);
        endcase
    end

    assign rem_sh = {rem_reg[W-2:0], dq_reg[W-1]};

    // the one wide adder, shared by product accumulation and division
    always_comb
    begin
        case (state_reg)
            SS_MAC:
            begin
                add_a   = acc_reg;
                add_b   = mcand_reg;
                add_sub = uop.neg;
            end
            SS_DADD:
            begin
                add_a   = dq_reg;
                add_b   = ad_reg;
                add_sub = 1'b0;
            end
            SS_DIV:
            begin
                add_a   = rem_sh;
                add_b   = {ad_reg[W-2:0], 1'b0};
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                             : ({1'b0, add_a} + {1'b0, add_b});
    assign q_fit   = !add_res[W];

    // round-half-away quotient, saturated to the signed coefficient range
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign mag_q    = (dq_reg > W'(lim)) ? lim : dq_reg[CW-1:0];
    assign coef_val = neg_reg ? (~mag_q + CW'(1)) : mag_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SS_IDLE;
            valid_reg   <= 1'b0;
            uop_idx_reg <= '0;
            k_reg       <= K_CONST;
            bit_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                SS_IDLE:
                begin
                    if (start)
                    begin
                        p0_reg      <= p0;
                        p1_reg      <= p1;
                        p2_reg      <= p2;
                        p3_reg      <= p3;
                        p4_reg      <= p4;
                        r0_reg      <= r0;
                        r1_reg      <= r1;
                        r2_reg      <= r2;
                        drop_reg    <= overflow;
                        used_reg    <= qlsf_pkg::USED_W'(p0);
                        sing_reg    <= 1'b0;
                        uop_idx_reg <= '0;
                        state_reg   <= SS_LOAD;
                    end
                end
                SS_LOAD:
                begin
                    mcand_reg  <= a_val;
                    mplier_reg <= b_val;
                    if (uop.first)
                    begin
                        acc_reg <= '0;
                    end
                    state_reg <= SS_MAC;
                end
                SS_MAC:
                begin
                    if (mplier_reg == '0)
                    begin
                        if (uop.last)
                        begin
                            file_reg[uop.dst] <= acc_reg;
                        end
                        if (uop_idx_reg == qlsf_pkg::UOP_LAST)
                        begin
                            if (det == '0)
                            begin
                                sing_reg  <= 1'b1;
                                c0_reg    <= '0;
                                c1_reg    <= '0;
                                c2_reg    <= '0;
                                valid_reg <= 1'b1;
                                state_reg <= SS_DONE;
                            end
                            else
                            begin
                                k_reg     <= K_CONST;
                                state_reg <= SS_DLOAD;
                            end
                        end
                        else
                        begin
                            uop_idx_reg <= uop_idx_reg + qlsf_pkg::UOP_W'(1);
                            state_reg   <= SS_LOAD;
                        end
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= add_res[W-1:0];
                        end
                        mcand_reg  <= {mcand_reg[W-2:0], 1'b0};
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                SS_DLOAD:
                begin
                    neg_reg   <= rd_data[W-1] ^ det[W-1];
                    dq_reg    <= num_sh;
                    ad_reg    <= mag_d;
                    rem_reg   <= '0;
                    state_reg <= SS_DADD;
                end
                SS_DADD:
                begin
                    // add |det| so that dividing by 2|det| rounds to nearest
                    dq_reg    <= add_res[W-1:0];
                    bit_reg   <= '0;
                    state_reg <= SS_DIV;
                end
                SS_DIV:
                begin
                    rem_reg <= q_fit ? add_res[W-1:0] : rem_sh;
                    dq_reg  <= {dq_reg[W-2:0], q_fit};
                    if (bit_reg == BIT_W'(W - 1))
                    begin
                        state_reg <= SS_DFIN;
                    end
                    else
                    begin
                        bit_reg <= bit_reg + BIT_W'(1);
                    end
                end
                SS_DFIN:
                begin
                    case (k_reg)
                        K_CONST:  c0_reg <= coef_val;
                        K_LINEAR: c1_reg <= coef_val;
                        default:  c2_reg <= coef_val;
                    endcase
                    if (k_reg == K_SQUARE)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= SS_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= SS_DLOAD;
                    end
                end
                SS_DONE:
                begin
                    if (out_ready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= SS_IDLE;
                    end
                end
                default: state_reg <= SS_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != SS_IDLE);
    assign out_valid      = valid_reg;
    assign coef_const     = c0_reg;
    assign coef_linear    = c1_reg;
    assign coef_square    = c2_reg;
    assign singular       = sing_reg;
    assign points_dropped = drop_reg;
    assign points_used    = used_reg;

endmodule

// ===== sv/qlsf_checker.sv =====
// ----------------------------------------------------------------------------
// qlsf_checker
// Port-level checks of the quadratic fit, bound to the top level.
// ----------------------------------------------------------------------------
`include "quadratic_least_squares_fit_assert.svh"

module qlsf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [qlsf_pkg::COEF_W-1:0]   coef_const,
    input logic [qlsf_pkg::COEF_W-1:0]   coef_linear,
    input logic [qlsf_pkg::COEF_W-1:0]   coef_square,
    input logic                          singular
);

    // a result waiting for the sink stays offered
`QLSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a singular system carries all-zero coefficients
`QLSF_ASSERT_IMPLY(a_sing_zero, out_valid && singular, (coef_const == '0) && (coef_linear == '0) && (coef_square == '0))

    // a point transfer always takes the intake out of idle, so ready is low after it
`QLSF_ASSERT_NEXT(a_intake_busy, in_valid && in_ready, !in_ready)

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (points.valid),
    .in_ready    (points.ready),
    .out_valid   (coefs.valid),
    .out_ready   (coefs.ready),
    .coef_const  (coefs.coef_const),
    .coef_linear (coefs.coef_linear),
    .coef_square (coefs.coef_square),
    .singular    (coefs.singular)
);
